### hdl/gtg_pkg.sv
// Shared constants, types and helper functions for the go-to-goal controller.
package gtg_pkg;

  localparam int CORDIC_ITER_DEF = 16;
  localparam int ATAN_LEN        = 32;
  localparam int CW              = 38;  // CORDIC x/y datapath width
  localparam int ZW              = 34;  // Q4.30 angle accumulator width
  localparam int AW              = 16;  // Q3.13 angle width
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [16:0]   PI_Q13      = 17'sd25736;
  localparam logic [15:0]          INV_GAIN    = 16'd39797;
  localparam logic signed [CW-1:0] ONE_Q28     = CW'(64'sd268435456);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GOAL_X   = 3'd0,
    REG_GOAL_Y   = 3'd1,
    REG_LIN_GAIN = 3'd2,
    REG_ANG_GAIN = 3'd3,
    REG_LIN_LIM  = 3'd4,
    REG_ANG_LIM  = 3'd5,
    REG_RADIUS   = 3'd6
  } reg_idx_t;

  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  // wrap a Q3.13 angle into (-pi, pi]
  function automatic logic signed [AW-1:0] wrap_q13(input logic signed [16:0] a);
    logic signed [16:0] t;
    t = a;
    if (t > PI_Q13) t = t - (PI_Q13 <<< 1);
    if (t <= -PI_Q13) t = t + (PI_Q13 <<< 1);
    return t[AW-1:0];
  endfunction

  // Q4.30 accumulator to Q3.13, round half up, then wrap
  function automatic logic signed [AW-1:0] round_angle(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] t;
    t = (z + ZW'(65536)) >>> 17;
    return wrap_q13(t[16:0]);
  endfunction

endpackage

### hdl/gtg_if.sv
// Channel interfaces: pose input, velocity command output, register writes.
interface gtg_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source (output valid, pos_x, pos_y, quat_w, quat_x, quat_y, quat_z,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, quat_w, quat_x, quat_y, quat_z,
                  output ready);
endinterface

interface gtg_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] lin_vel;
  logic signed [15:0] ang_vel;
  logic               arrived;
  modport source (output valid, lin_vel, ang_vel, arrived, input ready);
  modport sink   (input valid, lin_vel, ang_vel, arrived, output ready);
endinterface

interface gtg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/gtg_cordic.sv
// Pipelined vectoring CORDIC: quadrant pre-rotation plus one stage per iteration.
module gtg_cordic #(
  parameter int ITER = gtg_pkg::CORDIC_ITER_DEF
) (
  input  logic                             clk,
  input  logic [ITER:0]                    en,
  input  logic signed [gtg_pkg::CW-1:0]    x_in,
  input  logic signed [gtg_pkg::CW-1:0]    y_in,
  output logic signed [gtg_pkg::CW-1:0]    x_out,
  output logic signed [gtg_pkg::ZW-1:0]    z_out,
  output logic                             zero_out
);
  import gtg_pkg::*;

  logic signed [CW-1:0] xs [ITER+1];
  logic signed [CW-1:0] ys [ITER+1];
  logic signed [ZW-1:0] zs [ITER+1];
  logic                 zf [ITER+1];

  // pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (en[0]) begin
      zf[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          xs[0] <= y_in;
          ys[0] <= -x_in;
          zs[0] <= HALF_PI_Q30;
        end else begin
          xs[0] <= -y_in;
          ys[0] <= x_in;
          zs[0] <= -HALF_PI_Q30;
        end
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ATN = ZW'(ATAN_TAB[i]);
    logic signed [CW-1:0] sx, sy;
    assign sx = ys[i] >>> i;
    assign sy = xs[i] >>> i;
    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        zf[i+1] <= zf[i];
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + sx;
          ys[i+1] <= ys[i] - sy;
          zs[i+1] <= zs[i] + ATN;
        end else begin
          xs[i+1] <= xs[i] - sx;
          ys[i+1] <= ys[i] + sy;
          zs[i+1] <= zs[i] - ATN;
        end
      end
    end
  end

  assign x_out    = xs[ITER];
  assign z_out    = zs[ITER];
  assign zero_out = zf[ITER];

endmodule

### hdl/go_to_goal_heading_controller_unit.sv
// Go-to-goal heading controller: pose in, clamped unicycle velocity command out.
// Pipeline: CORDIC_ITERATIONS + 7 register stages from pose beat to command beat
// (two front stages, pre-rotation plus one stage per CORDIC iteration, four back stages).
// Throughput: one pose per cycle; each stage holds only when it is full and the next holds.
// The two CORDIC pipelines (yaw and bearing) run side by side and set the depth.
// Reset: synchronous; clears all stage valid bits and loads register defaults.
module go_to_goal_heading_controller_unit #(
  parameter int CORDIC_ITERATIONS = gtg_pkg::CORDIC_ITER_DEF
) (
  input  logic clk,
  input  logic rst,
  gtg_pose_if.sink   pose,
  gtg_cmd_if.source  cmd,
  gtg_cfg_if.sink    cfg
);
  import gtg_pkg::*;

  localparam int ITER = CORDIC_ITERATIONS;
  localparam int NS   = ITER + 7;     // total register stages
  localparam int SC   = 2;            // first CORDIC stage
  localparam int SP0  = ITER + 3;     // angle round / magnitude scale
  localparam int SP1  = ITER + 4;     // distance, arrival, heading error
  localparam int SP2  = ITER + 5;     // gain products
  localparam int SP3  = ITER + 6;     // clamp, output register
  localparam int DW   = CW - 1;       // distance width
  localparam int MPW  = CW - 1 + 16;  // magnitude product width

  // configuration registers
  logic signed [31:0] goal_x, goal_y;
  logic [15:0]        lin_gain, ang_gain;
  logic [14:0]        lin_limit, ang_limit;
  logic [30:0]        arrive_radius;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x        <= '0;
      goal_y        <= '0;
      lin_gain      <= 16'd205;
      ang_gain      <= 16'd512;
      lin_limit     <= 15'd128;
      ang_limit     <= 15'd307;
      arrive_radius <= 31'd6554;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_GOAL_X:   goal_x        <= cfg.data;
        REG_GOAL_Y:   goal_y        <= cfg.data;
        REG_LIN_GAIN: lin_gain      <= cfg.data[15:0];
        REG_ANG_GAIN: ang_gain      <= cfg.data[15:0];
        REG_LIN_LIM:  lin_limit     <= cfg.data[14:0];
        REG_ANG_LIM:  ang_limit     <= cfg.data[14:0];
        REG_RADIUS:   arrive_radius <= cfg.data[30:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // valid bits and per-stage hold chain; a stage loads when it is empty or
  // its successor moves, so bubbles collapse and nothing is lost on a stall
  logic [NS-1:0] vld;
  logic [NS:0]   en;

  assign en[NS] = cmd.ready;
  for (genvar s = 0; s < NS; s++) begin : g_en
    assign en[s] = !vld[s] || en[s+1];
  end
  assign pose.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= pose.valid;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) vld[s] <= vld[s-1];
      end
    end
  end

  // stage 0: quaternion products, goal offset
  logic signed [31:0] p_wz, p_xy, p_yy, p_zz;
  logic signed [32:0] dx0, dy0;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_wz <= pose.quat_w * pose.quat_z;
      p_xy <= pose.quat_x * pose.quat_y;
      p_yy <= pose.quat_y * pose.quat_y;
      p_zz <= pose.quat_z * pose.quat_z;
      dx0  <= {goal_x[31], goal_x} - {pose.pos_x[31], pose.pos_x};
      dy0  <= {goal_y[31], goal_y} - {pose.pos_y[31], pose.pos_y};
    end
  end

  // stage 1: yaw vector, num = 2(wz+xy), den = 1 - 2(y^2+z^2), Q10.28
  logic signed [CW-1:0] num1, den1, dx1, dy1;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      num1 <= (CW'(p_wz) + CW'(p_xy)) <<< 1;
      den1 <= ONE_Q28 - ((CW'(p_yy) + CW'(p_zz)) <<< 1);
      dx1  <= CW'(dx0);
      dy1  <= CW'(dy0);
    end
  end

  // CORDIC pipelines
  logic signed [CW-1:0] yaw_x, brg_x;
  logic signed [ZW-1:0] yaw_z, brg_z;
  logic                 yaw_zero, brg_zero;

  gtg_cordic #(.ITER(ITER)) u_yaw (
    .clk      (clk),
    .en       (en[SC+ITER:SC]),
    .x_in     (den1),
    .y_in     (num1),
    .x_out    (yaw_x),
    .z_out    (yaw_z),
    .zero_out (yaw_zero)
  );

  gtg_cordic #(.ITER(ITER)) u_brg (
    .clk      (clk),
    .en       (en[SC+ITER:SC]),
    .x_in     (dx1),
    .y_in     (dy1),
    .x_out    (brg_x),
    .z_out    (brg_z),
    .zero_out (brg_zero)
  );

  // P0: round angles to Q3.13, scale magnitude by 1/K
  logic signed [AW-1:0] yaw_a, brg_a;
  logic [MPW-1:0]       mag_prod;
  logic [CW-2:0]        brg_mag;
  // only the bearing magnitude is needed; yaw_x is the matching yaw magnitude
  assign brg_mag = (brg_x < 0 || brg_zero) ? '0 : brg_x[CW-2:0];

  always_ff @(posedge clk) begin
    if (en[SP0]) begin
      yaw_a    <= yaw_zero ? '0 : round_angle(yaw_z);
      brg_a    <= brg_zero ? '0 : round_angle(brg_z);
      mag_prod <= MPW'(brg_mag) * MPW'(INV_GAIN);
    end
  end

  // P1: distance, arrival test, heading error
  logic [MPW:0]         mag_rnd;
  logic [DW-1:0]        distance;
  logic signed [AW-1:0] err;
  logic                 arr1;
  logic signed [16:0]   err_raw;
  assign mag_rnd = {1'b0, mag_prod} + (MPW+1)'(32768);
  assign err_raw = 17'(brg_a) - 17'(yaw_a);

  always_ff @(posedge clk) begin
    if (en[SP1]) begin
      distance <= mag_rnd[16 +: DW];
      arr1     <= mag_rnd[16 +: DW] < DW'(arrive_radius);
      err      <= wrap_q13(err_raw);
    end
  end

  // P2: gain products
  logic [DW+15:0] lin_prod;
  logic [30:0]    ang_prod;
  logic           err_neg, arr2;
  logic [14:0]    err_abs;
  assign err_abs = err[AW-1] ? 15'(-err) : err[14:0];

  always_ff @(posedge clk) begin
    if (en[SP2]) begin
      lin_prod <= (DW+16)'(lin_gain) * (DW+16)'(distance);
      ang_prod <= 31'(ang_gain) * 31'(err_abs);
      err_neg  <= err[AW-1];
      arr2     <= arr1;
    end
  end

  // P3: round, clamp, sign, output register
  logic [DW+16:0] lin_rnd;
  logic [31:0]    ang_rnd;
  logic [14:0]    v_c, w_c;
  assign lin_rnd = {1'b0, lin_prod} + (DW+17)'(32768);
  assign ang_rnd = {1'b0, ang_prod} + 32'd4096;
  assign v_c = (lin_rnd[DW+16:16] > (DW+1)'(lin_limit)) ? lin_limit : lin_rnd[30:16];
  assign w_c = (ang_rnd[31:13] > 19'(ang_limit)) ? ang_limit : ang_rnd[27:13];

  logic signed [15:0] lin_o, ang_o;
  logic               arr_o;
  always_ff @(posedge clk) begin
    if (en[SP3]) begin
      arr_o <= arr2;
      lin_o <= arr2 ? '0 : {1'b0, v_c};
      ang_o <= arr2 ? '0 : (err_neg ? -{1'b0, w_c} : {1'b0, w_c});
    end
  end

  assign cmd.valid   = vld[NS-1];
  assign cmd.lin_vel = lin_o;
  assign cmd.ang_vel = ang_o;
  assign cmd.arrived = arr_o;

  // arrival forces a full stop
  a_arrive_stop: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.arrived |-> cmd.lin_vel == 0 && cmd.ang_vel == 0)
    else $error("arrived with nonzero velocity");

  // linear command never reverses and never exceeds its limit
  a_lin_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.valid |-> !cmd.lin_vel[15] && cmd.lin_vel[14:0] <= lin_limit)
    else $error("lin_vel out of bounds");

  // angular command stays within +/- limit
  a_ang_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.valid |-> $signed(cmd.ang_vel) <= $signed({1'b0, ang_limit}) &&
                  $signed(cmd.ang_vel) >= -$signed({1'b0, ang_limit}))
    else $error("ang_vel out of bounds");

  // a stalled output stage holds its command
  a_hold: assert property (@(posedge clk) disable iff (rst)
    vld[NS-1] && !cmd.ready |=> vld[NS-1] && $stable(lin_o) && $stable(ang_o))
    else $error("output stage changed while stalled");

endmodule
